### sv/bbpa_pkg.sv
package bbpa_pkg;

  localparam int MAX_BLOCKS_DEFAULT = 256;
  localparam int ADDR_BITS_DEFAULT  = 32;

  localparam int WORD_BITS = 32;

  localparam logic [16:0] MIN_BLOCK_BYTES = 17'd4;
  localparam logic [16:0] MAX_BLOCK_BYTES = 17'd65536;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_ALIGN = 3'd3;
  localparam logic [2:0] ST_FREE  = 3'd4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] CFG_POOL_BASE       = 2'd0;
  localparam logic [1:0] CFG_BYTES_PER_BLOCK = 2'd1;
  localparam logic [1:0] CFG_BLOCKS_IN_USE   = 2'd2;

  localparam logic [31:0] POOL_BASE_RESET       = 32'd0;
  localparam logic [16:0] BYTES_PER_BLOCK_RESET = 17'd4;
  localparam logic [8:0]  BLOCKS_IN_USE_RESET   = 9'd256;

endpackage

### sv/bitmap_block_pool_allocator_unit.sv
// Channel   Handshake                Payload
// cfg       cfg_valid / cfg_ready    cfg_index[1:0], cfg_data[31:0]
// in        in_valid / in_ready      action, block_address[31:0]
// out       out_valid / out_ready    status[2:0], granted_address[31:0], block_number[7:0]
//
// One request at a time. Allocate reads and checks the map one word at a time,
// bounded by the single read port of the map memory, then forms the address.
// Free runs a span multiply, range check, 9 restoring division steps, one map
// read and write back. Reset clears control state and the map valid bits;
// no clearing pass. A held result does not block the next request from starting.
module bitmap_block_pool_allocator_unit #(
  parameter int MAX_BLOCKS = bbpa_pkg::MAX_BLOCKS_DEFAULT,
  parameter int ADDR_BITS  = bbpa_pkg::ADDR_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] granted_address,
  output logic [7:0]  block_number
);

  localparam int MAP_WORDS = (MAX_BLOCKS + 31) / 32;
  localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int AW        = WORD_W + 5;
  localparam int SCAN_W    = (WORD_W + 6 > 10) ? WORD_W + 6 : 10;
  localparam logic [31:0] GRANT_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_ARD, S_ACHK, S_AMUL, S_AADD,
    S_SPAN, S_RANGE, S_DIV, S_FRD, S_FCHK, S_DONE
  } state_t;

  state_t st;

  logic [31:0] pool_base;
  logic [16:0] bytes_per_block;
  logic [8:0]  blocks_in_use;

  logic [31:0] map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] word_valid;
  logic [31:0] rd_data;
  logic        rd_valid;

  logic              rd_en;
  logic [WORD_W-1:0] rd_addr;
  logic              wr_en;
  logic [WORD_W-1:0] wr_addr;
  logic [31:0]       wr_data;

  logic [31:0]       addr_r;
  logic [WORD_W-1:0] scan_w;
  logic [AW-1:0]     alloc_idx;
  logic [AW+16:0]    prod;
  logic [25:0]       span;
  logic [25:0]       rem;
  logic [8:0]        quot;
  logic [3:0]        div_k;
  logic [2:0]        res_status;
  logic [31:0]       res_grant;
  logic [7:0]        res_num;

  logic [16:0]       size_eff;
  logic [8:0]        count_eff;
  logic [31:0]       word;
  logic [SCAN_W-1:0] scan_end;
  logic              last_word;
  logic [31:0]       word_mask;
  logic [31:0]       free_bits;
  logic [4:0]        found_j;
  logic [25:0]       trial;
  logic              ge;
  logic [31:0]       offset;
  logic [31:0]       clear_mask;

  always_comb begin
    if (bytes_per_block < bbpa_pkg::MIN_BLOCK_BYTES) begin
      size_eff = bbpa_pkg::MIN_BLOCK_BYTES;
    end else if (bytes_per_block > bbpa_pkg::MAX_BLOCK_BYTES) begin
      size_eff = bbpa_pkg::MAX_BLOCK_BYTES;
    end else begin
      size_eff = bytes_per_block;
    end
    if (32'(blocks_in_use) > 32'(MAX_BLOCKS)) begin
      count_eff = 9'(MAX_BLOCKS);
    end else begin
      count_eff = blocks_in_use;
    end
  end

  always_comb begin
    word      = rd_valid ? rd_data : 32'd0;
    scan_end  = SCAN_W'({scan_w, 5'd0}) + SCAN_W'(bbpa_pkg::WORD_BITS);
    last_word = scan_end >= SCAN_W'(count_eff);
    if (last_word && count_eff[4:0] != 5'd0) begin
      word_mask = (32'd1 << count_eff[4:0]) - 32'd1;
    end else begin
      word_mask = 32'hFFFF_FFFF;
    end
    free_bits = ~word & word_mask;
    found_j   = 5'd0;
    for (int j = 31; j >= 0; j--) begin
      if (free_bits[j]) begin
        found_j = 5'(j);
      end
    end
    trial      = 26'(size_eff) << div_k;
    ge         = rem >= trial;
    offset     = addr_r - pool_base;
    clear_mask = ~(32'd1 << quot[4:0]);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_w;
    wr_en   = 1'b0;
    wr_addr = scan_w;
    wr_data = word | (32'd1 << found_j);
    unique case (st)
      S_ARD: begin
        rd_en = 1'b1;
      end
      S_ACHK: begin
        wr_en = |free_bits;
      end
      S_FRD: begin
        rd_en   = (rem == 26'd0);
        rd_addr = WORD_W'(quot[8:5]);
      end
      S_FCHK: begin
        wr_en   = word[quot[4:0]];
        wr_addr = WORD_W'(quot[8:5]);
        wr_data = word & clear_mask;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= map_mem[rd_addr];
      rd_valid <= word_valid[rd_addr];
    end
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (wr_en) begin
      word_valid[wr_addr] <= 1'b1;
    end
  end

  assign cfg_ready = !rst;
  assign in_ready  = (st == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base       <= bbpa_pkg::POOL_BASE_RESET;
      bytes_per_block <= bbpa_pkg::BYTES_PER_BLOCK_RESET;
      blocks_in_use   <= bbpa_pkg::BLOCKS_IN_USE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bbpa_pkg::CFG_POOL_BASE:       pool_base       <= cfg_data;
        bbpa_pkg::CFG_BYTES_PER_BLOCK: bytes_per_block <= cfg_data[16:0];
        bbpa_pkg::CFG_BLOCKS_IN_USE:   blocks_in_use   <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && st != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            addr_r <= block_address;
            scan_w <= '0;
            if (action == bbpa_pkg::ACT_FREE) begin
              st <= S_SPAN;
            end else if (count_eff == 9'd0) begin
              res_status <= bbpa_pkg::ST_FULL;
              res_grant  <= 32'd0;
              res_num    <= 8'd0;
              st         <= S_DONE;
            end else begin
              st <= S_ARD;
            end
          end
        end
        S_ARD: begin
          st <= S_ACHK;
        end
        S_ACHK: begin
          if (|free_bits) begin
            alloc_idx <= {scan_w, found_j};
            st        <= S_AMUL;
          end else if (last_word) begin
            res_status <= bbpa_pkg::ST_FULL;
            res_grant  <= 32'd0;
            res_num    <= 8'd0;
            st         <= S_DONE;
          end else begin
            scan_w <= scan_w + WORD_W'(1);
            st     <= S_ARD;
          end
        end
        S_AMUL: begin
          prod <= alloc_idx * size_eff;
          st   <= S_AADD;
        end
        S_AADD: begin
          res_status <= bbpa_pkg::ST_OK;
          res_grant  <= (pool_base + 32'(prod)) & GRANT_MASK;
          res_num    <= 8'(alloc_idx);
          st         <= S_DONE;
        end
        S_SPAN: begin
          span <= size_eff * count_eff;
          st   <= S_RANGE;
        end
        S_RANGE: begin
          if (addr_r < pool_base || offset >= 32'(span)) begin
            res_status <= bbpa_pkg::ST_RANGE;
            res_grant  <= 32'd0;
            res_num    <= 8'd0;
            st         <= S_DONE;
          end else begin
            rem   <= 26'(offset);
            quot  <= 9'd0;
            div_k <= 4'd8;
            st    <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= ge ? rem - trial : rem;
          quot <= {quot[7:0], ge};
          if (div_k == 4'd0) begin
            st <= S_FRD;
          end else begin
            div_k <= div_k - 4'd1;
          end
        end
        S_FRD: begin
          if (rem != 26'd0) begin
            res_status <= bbpa_pkg::ST_ALIGN;
            res_grant  <= 32'd0;
            res_num    <= 8'd0;
            st         <= S_DONE;
          end else begin
            st <= S_FCHK;
          end
        end
        S_FCHK: begin
          res_grant <= 32'd0;
          if (word[quot[4:0]]) begin
            res_status <= bbpa_pkg::ST_OK;
            res_num    <= quot[7:0];
          end else begin
            res_status <= bbpa_pkg::ST_FREE;
            res_num    <= 8'd0;
          end
          st <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            granted_address <= res_grant;
            block_number    <= res_num;
            st              <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### dv/bitmap_block_pool_allocator_unit_tb.sv
`timescale 1ns / 100ps

module bitmap_block_pool_allocator_unit_tb;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_REQUESTS = 212;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] grant;
    logic [7:0]  number;
  } pool_result_t;

  typedef struct packed {
    logic         is_cfg;
    logic [1:0]   reg_index;
    logic [31:0]  reg_data;
    logic         act;
    logic [31:0]  addr;
    logic         typed;
    pool_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [31:0] block_address;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [31:0] granted_address;
  logic [7:0]  block_number;

  logic [31:0] pool_base_reg = bbpa_pkg::POOL_BASE_RESET;
  logic [16:0] block_size_reg = bbpa_pkg::BYTES_PER_BLOCK_RESET;
  logic [8:0]  pool_len_reg = bbpa_pkg::BLOCKS_IN_USE_RESET;
  logic [bbpa_pkg::MAX_BLOCKS_DEFAULT-1:0] block_used = '0;

  pool_result_t pending_results[$];
  pool_result_t head_result;
  stim_row_t    directed_rows[$];

  int errors;
  int results_seen;
  int requests_sent;
  int reg_writes;
  int burst_left;
  int tally[2][8];

  bitmap_block_pool_allocator_unit dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .block_address   (block_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_address (granted_address),
    .block_number    (block_number)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint unsigned block_bytes();
    if (block_size_reg < bbpa_pkg::MIN_BLOCK_BYTES) return 64'(bbpa_pkg::MIN_BLOCK_BYTES);
    if (block_size_reg > bbpa_pkg::MAX_BLOCK_BYTES) return 64'(bbpa_pkg::MAX_BLOCK_BYTES);
    return 64'(block_size_reg);
  endfunction

  function automatic longint unsigned pool_blocks();
    if (32'(pool_len_reg) > 32'(bbpa_pkg::MAX_BLOCKS_DEFAULT)) begin
      return 64'(bbpa_pkg::MAX_BLOCKS_DEFAULT);
    end
    return 64'(pool_len_reg);
  endfunction

  task automatic predict_pool_op(input logic act, input logic [31:0] addr,
                                 output pool_result_t res);
    longint unsigned bytes, nblk, span, offset, wide;
    int idx;
    bit found;
    bytes = block_bytes();
    nblk = pool_blocks();
    res = '0;
    found = 1'b0;
    if (act == bbpa_pkg::ACT_ALLOC) begin
      res.status = bbpa_pkg::ST_FULL;
      for (idx = 0; idx < nblk && !found; idx++) begin
        if (!block_used[idx]) begin
          found = 1'b1;
          block_used[idx] = 1'b1;
          wide = pool_base_reg + idx * bytes;
          res.status = bbpa_pkg::ST_OK;
          res.number = idx[7:0];
          res.grant = wide[31:0];
        end
      end
    end else begin
      span = bytes * nblk;
      if (addr < pool_base_reg || addr - pool_base_reg >= span) begin
        res.status = bbpa_pkg::ST_RANGE;
      end else begin
        offset = addr - pool_base_reg;
        if (offset % bytes != 0) begin
          res.status = bbpa_pkg::ST_ALIGN;
        end else begin
          idx = int'(offset / bytes);
          if (!block_used[idx]) begin
            res.status = bbpa_pkg::ST_FREE;
          end else begin
            block_used[idx] = 1'b0;
            res.status = bbpa_pkg::ST_OK;
            res.number = idx[7:0];
          end
        end
      end
    end
  endtask

  function automatic void add_req(input logic act, input logic [31:0] addr,
                                  input logic typed, input logic [2:0] st,
                                  input logic [31:0] grant, input logic [7:0] num);
    stim_row_t row;
    row = '0;
    row.act = act;
    row.addr = addr;
    row.typed = typed;
    row.want.status = st;
    row.want.grant = grant;
    row.want.number = num;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [1:0] index, input logic [31:0] data);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_index = index;
    row.reg_data = data;
    directed_rows.push_back(row);
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      bbpa_pkg::CFG_POOL_BASE:       pool_base_reg = data;
      bbpa_pkg::CFG_BYTES_PER_BLOCK: block_size_reg = data[16:0];
      bbpa_pkg::CFG_BLOCKS_IN_USE:   pool_len_reg = data[8:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic issue_request(input logic act, input logic [31:0] addr,
                               input logic typed, input pool_result_t want);
    pool_result_t pred;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(40, 120))
                                               : int'($urandom_range(1, 12));
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    action <= act;
    block_address <= addr;
    do @(posedge clk); while (!in_ready);
    predict_pool_op(act, addr, pred);
    pending_results.push_back(typed ? want : pred);
    tally[act][pred.status]++;
    requests_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d address %h block %0d",
                 $time, status, granted_address, block_number);
        errors++;
      end else begin
        head_result = pending_results.pop_front();
        if (status !== head_result.status) begin
          $display("%0t: status expected %0d, got %0d", $time, head_result.status, status);
          errors++;
        end
        if (granted_address !== head_result.grant) begin
          $display("%0t: granted_address expected %h, got %h",
                   $time, head_result.grant, granted_address);
          errors++;
        end
        if (block_number !== head_result.number) begin
          $display("%0t: block_number expected %0d, got %0d",
                   $time, head_result.number, block_number);
          errors++;
        end
        results_seen++;
      end
    end
  end

  initial begin
    int mode, span_len, next_hold;
    next_hold = 300;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (results_seen >= next_hold) begin
        next_hold = (next_hold == 300) ? 1100 : 32'h7fff_ffff;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode = int'($urandom_range(0, 3));
      span_len = int'($urandom_range(1, 60));
      repeat (span_len) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    stim_row_t row;
    logic act;
    logic [31:0] addr, base, cfg_word;
    logic [16:0] size_raw;
    logic [8:0] count_raw;
    longint unsigned bytes, nblk, wide;
    int phase, n, k, j, start, sel;
    bit got_one;

    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= bbpa_pkg::CFG_POOL_BASE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    action <= bbpa_pkg::ACT_ALLOC;
    block_address <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_req(bbpa_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 1'b1, bbpa_pkg::ST_OK, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_ALLOC, 32'h0, 1'b1, bbpa_pkg::ST_OK, 32'h4, 8'd1);
    add_req(bbpa_pkg::ACT_FREE, 32'h0, 1'b1, bbpa_pkg::ST_OK, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'h0, 1'b1, bbpa_pkg::ST_FREE, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'h2, 1'b1, bbpa_pkg::ST_ALIGN, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'd1024, 1'b1, bbpa_pkg::ST_RANGE, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'hFFFF_FFFF, 1'b1, bbpa_pkg::ST_RANGE, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'd1020, 1'b1, bbpa_pkg::ST_FREE, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'h4, 1'b1, bbpa_pkg::ST_OK, 32'h0, 8'd1);
    add_cfg(CFG_SPARE, 32'hFFFF_FFFF);
    add_cfg(bbpa_pkg::CFG_POOL_BASE, 32'hFFFF_FFFC);
    add_cfg(bbpa_pkg::CFG_BYTES_PER_BLOCK, 32'h0);
    add_cfg(bbpa_pkg::CFG_BLOCKS_IN_USE, 32'd2);
    add_req(bbpa_pkg::ACT_ALLOC, 32'h0, 1'b1, bbpa_pkg::ST_OK, 32'hFFFF_FFFC, 8'd0);
    add_req(bbpa_pkg::ACT_ALLOC, 32'h0, 1'b1, bbpa_pkg::ST_OK, 32'h0, 8'd1);
    add_req(bbpa_pkg::ACT_ALLOC, 32'h0, 1'b1, bbpa_pkg::ST_FULL, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'h0, 1'b1, bbpa_pkg::ST_RANGE, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'hFFFF_FFFC, 1'b1, bbpa_pkg::ST_OK, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'hFFFF_FFFF, 1'b1, bbpa_pkg::ST_ALIGN, 32'h0, 8'd0);
    add_cfg(bbpa_pkg::CFG_BLOCKS_IN_USE, 32'd0);
    add_req(bbpa_pkg::ACT_ALLOC, 32'h0, 1'b1, bbpa_pkg::ST_FULL, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'hFFFF_FFFC, 1'b1, bbpa_pkg::ST_RANGE, 32'h0, 8'd0);
    add_cfg(bbpa_pkg::CFG_POOL_BASE, 32'h0);
    add_cfg(bbpa_pkg::CFG_BYTES_PER_BLOCK, 32'h0001_FFFF);
    add_cfg(bbpa_pkg::CFG_BLOCKS_IN_USE, 32'h0000_01FF);
    add_req(bbpa_pkg::ACT_ALLOC, 32'h5555_AAAA, 1'b0, bbpa_pkg::ST_OK, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_ALLOC, 32'hAAAA_5555, 1'b0, bbpa_pkg::ST_OK, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'h0001_0000, 1'b0, bbpa_pkg::ST_OK, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'h0001_0004, 1'b1, bbpa_pkg::ST_ALIGN, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'h0100_0000, 1'b1, bbpa_pkg::ST_RANGE, 32'h0, 8'd0);
    add_req(bbpa_pkg::ACT_FREE, 32'h00FF_0000, 1'b1, bbpa_pkg::ST_FREE, 32'h0, 8'd0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        settle();
        write_reg(row.reg_index, row.reg_data);
      end else begin
        issue_request(row.act, row.addr, row.typed, row.want);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          base = 32'h0; size_raw = 17'd4; count_raw = 9'd1;
        end
        1: begin
          base = 32'hFFFF_FFFF; size_raw = 17'd65536; count_raw = 9'd256;
        end
        2: begin
          base = 32'h8000_0000; size_raw = 17'd3; count_raw = 9'd300;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: base = $urandom();
            1: base = 32'hFFFF_FFFF - $urandom_range(0, 4096);
            2: base = $urandom_range(0, 1024) * 4;
            default: base = $urandom() & 32'hFFFF_0000;
          endcase
          case ($urandom_range(0, 9))
            0: size_raw = 17'($urandom_range(0, 3));
            1: size_raw = 17'($urandom_range(65537, 131071));
            2: size_raw = 17'd65536;
            default: size_raw = 17'($urandom_range(4, 300));
          endcase
          case ($urandom_range(0, 9))
            0: count_raw = 9'd0;
            1: count_raw = 9'($urandom_range(257, 511));
            2: count_raw = 9'd256;
            default: count_raw = 9'($urandom_range(1, 48));
          endcase
        end
      endcase
      settle();
      write_reg(bbpa_pkg::CFG_POOL_BASE, base);
      cfg_word = ($urandom() & 32'hFFFE_0000) | 32'(size_raw);
      write_reg(bbpa_pkg::CFG_BYTES_PER_BLOCK, cfg_word);
      cfg_word = ($urandom() & 32'hFFFF_FE00) | 32'(count_raw);
      write_reg(bbpa_pkg::CFG_BLOCKS_IN_USE, cfg_word);

      for (n = 0; n < PHASE_REQUESTS; n++) begin
        bytes = block_bytes();
        nblk = pool_blocks();
        sel = int'($urandom_range(0, 99));
        act = bbpa_pkg::ACT_FREE;
        addr = $urandom();
        got_one = 1'b0;
        if (sel < 48) begin
          act = bbpa_pkg::ACT_ALLOC;
        end else if (sel < 78 && nblk != 0) begin
          start = int'($urandom_range(0, 32'(nblk - 1)));
          for (k = 0; k < nblk && !got_one; k++) begin
            j = int'((start + k) % nblk);
            if (block_used[j]) begin
              got_one = 1'b1;
              wide = pool_base_reg + j * bytes;
              addr = wide[31:0];
            end
          end
          if (!got_one) act = bbpa_pkg::ACT_ALLOC;
        end else if (sel < 86 && nblk != 0) begin
          wide = pool_base_reg + $urandom_range(0, 32'(nblk - 1)) * bytes
                 + $urandom_range(1, 32'(bytes - 1));
          addr = wide[31:0];
        end else if (sel < 93) begin
          if ($urandom_range(0, 1) == 0)
            wide = pool_base_reg - $urandom_range(1, 64);
          else
            wide = pool_base_reg + bytes * nblk + $urandom_range(0, 64);
          addr = wide[31:0];
        end else if (sel < 97 && nblk != 0) begin
          wide = pool_base_reg + $urandom_range(0, 32'(nblk - 1)) * bytes;
          addr = wide[31:0];
        end
        issue_request(act, addr, 1'b0, '0);
      end
    end

    settle();
    repeat (40) @(posedge clk);
    $display("%0d requests, %0d register writes: %0d grants, %0d pool full, %0d frees",
             requests_sent, reg_writes, tally[bbpa_pkg::ACT_ALLOC][bbpa_pkg::ST_OK],
             tally[bbpa_pkg::ACT_ALLOC][bbpa_pkg::ST_FULL],
             tally[bbpa_pkg::ACT_FREE][bbpa_pkg::ST_OK]);
    $display("rejected frees: %0d out of range, %0d misaligned, %0d already free",
             tally[bbpa_pkg::ACT_FREE][bbpa_pkg::ST_RANGE],
             tally[bbpa_pkg::ACT_FREE][bbpa_pkg::ST_ALIGN],
             tally[bbpa_pkg::ACT_FREE][bbpa_pkg::ST_FREE]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/bbpa_pkg.sv
sv/bitmap_block_pool_allocator_unit.sv
dv/bitmap_block_pool_allocator_unit_tb.sv
